// ===== rtl/fsd_pkg.sv =====
// Shared widths, codes and reset values for the frame skip decider.
`timescale 1ns / 1ps
`default_nettype none
package fsd_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;

  localparam int TIME_W = 24;
  localparam int OP_W   = 2;
  localparam int MODE_W = 2;
  localparam int RUN_W  = 8;
  localparam int THR_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Multiplier operand widths: period*threshold, then that product*count.
  localparam int MUL_A_W = TIME_W + THR_W;
  localparam int MUL_B_W = THR_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_DECIDE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ADAPTIVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIXED    = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_Q8 = 2'd3;

  localparam logic [RUN_W-1:0] MAX_RUN_RST      = 8'd5;
  localparam logic [THR_W-1:0] THRESHOLD_Q8_RST = 10'd307;

endpackage
`default_nettype wire

// ===== rtl/fsd_hist_mem.sv =====
// Frame time history memory, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fsd_hist_mem
  import fsd_pkg::*;
#(
  parameter int DEPTH  = HISTORY_DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [TIME_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fsd_mul.sv =====
// Shared multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module fsd_mul
  import fsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frame_skip_decider_core.sv =====
// Frame skip decider top level: sequencer, window state and decision logic.
//  - Input channel (in_valid/in_ready) carries one transaction per frame event:
//    opcode record (push frame_time_us into the history window), decide
//    (answer skip for target_period_us) or clear (empty window, zero run).
//  - Output channel (out_valid/out_ready) returns exactly one transaction per
//    input transaction; skip is 1 only for a decide that chose to skip.
//  - Config channel (cfg_valid/cfg_ready) writes skip_enable, skip_mode,
//    max_run and threshold_q8 by index; always ready, write only when idle.
//  - Sequence from accept to out_valid: record, clear and any decide with no
//    compare to run (disabled, non-adaptive, empty window) go straight to the
//    done step; an adaptive decide first makes two passes through the shared
//    multiplier (period*threshold, then *count) and then a compare step.
//    in_ready returns with out_valid, so a new item is accepted only once the
//    previous one has finished.
//  - A new item is accepted while a result waits in the output register; if
//    the receiver stalls, that next item holds in its final step until the
//    output register frees up.
//  - Reset clears the window, run counter, parity and config registers to
//    their defaults. History memory is not cleared; only entries written
//    since the last clear or reset are ever used.
`timescale 1ns / 1ps
`default_nettype none
module frame_skip_decider_core
  import fsd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input transactions
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [OP_W-1:0]       opcode,
  input  wire logic [TIME_W-1:0]     frame_time_us,
  input  wire logic [TIME_W-1:0]     target_period_us,
  // result transactions
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       skip,
  // config writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W  = TIME_W + CNT_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_MUL_B = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state;

  // config registers
  logic              skip_enable;
  logic [MODE_W-1:0] skip_mode;
  logic [RUN_W-1:0]  max_run;
  logic [THR_W-1:0]  threshold_q8;

  // window and policy state
  logic [SUM_W-1:0]  window_sum;
  logic [CNT_W-1:0]  window_count;
  logic [SLOT_W-1:0] write_slot;
  logic [RUN_W-1:0]  skip_run;
  logic              fixed_parity;

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] ft_q;
  logic [TIME_W-1:0] tp_q;
  logic              adapt_q;

  logic              in_acc;
  logic              finish;
  logic              win_full;

  logic [TIME_W-1:0] old_time;
  logic              mem_we;

  logic              mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W-1:0] lhs;

  logic              want;
  logic              res;
  logic [RUN_W-1:0]  skip_run_next;
  logic              parity_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign finish    = (state == ST_DONE) && (!out_valid || out_ready);
  assign win_full  = (window_count == CNT_W'(HISTORY_DEPTH));

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_enable  <= 1'b0;
      skip_mode    <= MODE_ADAPTIVE;
      max_run      <= MAX_RUN_RST;
      threshold_q8 <= THRESHOLD_Q8_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SKIP_ENABLE:  skip_enable  <= cfg_data[0];
        CFG_SKIP_MODE:    skip_mode    <= cfg_data[MODE_W-1:0];
        CFG_MAX_RUN:      max_run      <= cfg_data[RUN_W-1:0];
        CFG_THRESHOLD_Q8: threshold_q8 <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- history memory ----------------
  // Oldest entry is read at accept, so it is ready when the record finishes.
  assign mem_we = finish && (op_q == OP_RECORD);

  fsd_hist_mem #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_slot),
    .wdata (ft_q),
    .re    (in_acc),
    .raddr (write_slot),
    .rdata (old_time)
  );

  // ---------------- shared multiplier ----------------
  // Pass A: period * threshold. Pass B: (period * threshold) * count.
  assign mul_en = (state == ST_MUL_A) || (state == ST_MUL_B);
  always_comb begin
    if (state == ST_MUL_A) begin
      mul_a = MUL_A_W'(tp_q);
      mul_b = threshold_q8;
    end else begin
      mul_a = mul_p[MUL_A_W-1:0];
      mul_b = MUL_B_W'(window_count);
    end
  end

  fsd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sum * 256
  assign lhs = MUL_P_W'({window_sum, 8'd0});

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if ((opcode == OP_DECIDE) && skip_enable && (skip_mode == MODE_ADAPTIVE) &&
                (window_count != '0)) begin
              state <= ST_MUL_A;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_MUL_A: state <= ST_MUL_B;
        ST_MUL_B: state <= ST_CMP;
        ST_CMP:   state <= ST_DONE;
        ST_DONE: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q <= opcode;
      ft_q <= frame_time_us;
      tp_q <= target_period_us;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      adapt_q <= 1'b0;
    end else if (state == ST_CMP) begin
      adapt_q <= (lhs > mul_p);
    end
  end

  // ---------------- decision ----------------
  always_comb begin
    want          = 1'b0;
    res           = 1'b0;
    skip_run_next = '0;
    parity_next   = fixed_parity;
    if (skip_enable) begin
      if (skip_mode == MODE_ADAPTIVE) begin
        want = adapt_q;
      end else if (skip_mode == MODE_FIXED) begin
        parity_next = ~fixed_parity;
        want        = fixed_parity;  // skip when the toggled parity is 0
      end
      if (want && (skip_run < max_run)) begin
        res           = 1'b1;
        skip_run_next = skip_run + 1'b1;
      end
    end
  end

  // ---------------- state update ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      window_count <= '0;
      write_slot   <= '0;
      skip_run     <= '0;
      fixed_parity <= 1'b0;
    end else if (finish) begin
      case (op_q)
        OP_RECORD: begin
          if (win_full) begin
            window_sum <= window_sum - SUM_W'(old_time) + SUM_W'(ft_q);
          end else begin
            window_sum   <= window_sum + SUM_W'(ft_q);
            window_count <= window_count + 1'b1;
          end
          if (write_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
        end
        OP_DECIDE: begin
          skip_run     <= skip_run_next;
          fixed_parity <= parity_next;
        end
        OP_CLEAR: begin
          window_sum   <= '0;
          window_count <= '0;
          write_slot   <= '0;
          skip_run     <= '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      skip <= (op_q == OP_DECIDE) && res;
    end
  end

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_W'(HISTORY_DEPTH))
    else $error("window count above history depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (window_count == '0) |-> (window_sum == '0))
    else $error("empty window with nonzero sum");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("ready right after accepting a transaction");

  a_skip_only_decide: assert property (@(posedge clk) disable iff (rst)
    (finish && ((op_q != OP_DECIDE) || !skip_enable)) |=> !skip)
    else $error("skip raised for non-decide or disabled block");

  a_done_posts_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && in_ready))
    else $error("finished item did not post a result");

endmodule
`default_nettype wire
